FILE: design/averaged_temp_gas_alarm_blinker_top_assert.svh
// Assertion macros shared by the alarm blinker modules.
`ifndef AVERAGED_TEMP_GAS_ALARM_BLINKER_TOP_ASSERT_SVH
`define AVERAGED_TEMP_GAS_ALARM_BLINKER_TOP_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define ATGAB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checks that a condition never holds outside reset.
`define ATGAB_ASSERT_NEVER(label, cond, msg) \
  `ATGAB_ASSERT(label, !(cond), msg)

`endif

FILE: design/atgab_pkg.sv
// Package of constants and types for the averaged temperature and gas alarm blinker.
package atgab_pkg;

  localparam int WINDOW      = 100;
  localparam int SAMPLE_BITS = 12;
  localparam int PTR_W       = $clog2(WINDOW);
  localparam int SUM_W       = SAMPLE_BITS + $clog2(WINDOW);
  localparam int ADC_W       = 12;
  localparam int OUT_SUM_W   = 20;
  localparam int CMP_W       = (SUM_W > OUT_SUM_W) ? SUM_W : OUT_SUM_W;
  localparam int CNT_W       = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 20;
  localparam int QUEUE_DEPTH = 3;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [OUT_SUM_W-1:0] SUM_MAX = '1;

  localparam logic [OUT_SUM_W-1:0] TEMP_SUM_LIMIT_RST    = OUT_SUM_W'(37227);
  localparam logic [CNT_W-1:0]     GAS_PERIOD_TICKS_RST  = CNT_W'(100);
  localparam logic [CNT_W-1:0]     TEMP_PERIOD_TICKS_RST = CNT_W'(50);
  localparam logic [CNT_W-1:0]     BOTH_PERIOD_TICKS_RST = CNT_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_SUM_LIMIT    = 2'd0,
    REG_GAS_PERIOD_TICKS  = 2'd1,
    REG_TEMP_PERIOD_TICKS = 2'd2,
    REG_BOTH_PERIOD_TICKS = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [OUT_SUM_W-1:0] temp_sum_limit;
    logic [CNT_W-1:0]     gas_period_ticks;
    logic [CNT_W-1:0]     temp_period_ticks;
    logic [CNT_W-1:0]     both_period_ticks;
  } cfg_t;

  typedef struct packed {
    logic                 led_on;
    logic                 gas_alarm;
    logic                 temp_alarm;
    logic                 alarm_active;
    logic [OUT_SUM_W-1:0] window_sum;
  } result_t;

endpackage

FILE: design/atgab_if.sv
// Channel interfaces for samples, results and register writes.
interface atgab_in_if;
  import atgab_pkg::*;
  logic             valid;
  logic             ready;
  logic [ADC_W-1:0] adc_sample;
  logic             gas_detected;
  modport source (output valid, output adc_sample, output gas_detected, input ready);
  modport sink (input valid, input adc_sample, input gas_detected, output ready);
endinterface

interface atgab_out_if;
  import atgab_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 led_on;
  logic                 gas_alarm;
  logic                 temp_alarm;
  logic                 alarm_active;
  logic [OUT_SUM_W-1:0] window_sum;
  modport source (output valid, output led_on, output gas_alarm, output temp_alarm,
                  output alarm_active, output window_sum, input ready);
  modport sink (input valid, input led_on, input gas_alarm, input temp_alarm,
                input alarm_active, input window_sum, output ready);
endinterface

interface atgab_cfg_if;
  import atgab_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/atgab_ring_ram.sv
// Sample ring memory with a registered read port and per-entry valid bits.
`include "averaged_temp_gas_alarm_blinker_top_assert.svh"

module atgab_ring_ram (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              rd_en_i,
  input  logic [atgab_pkg::PTR_W-1:0]       rd_addr_i,
  output logic [atgab_pkg::SAMPLE_BITS-1:0] rd_data_o,
  input  logic                              wr_en_i,
  input  logic [atgab_pkg::PTR_W-1:0]       wr_addr_i,
  input  logic [atgab_pkg::SAMPLE_BITS-1:0] wr_data_i
);
  import atgab_pkg::*;

  logic [SAMPLE_BITS-1:0] mem_q [WINDOW];
  logic [WINDOW-1:0]      valid_q;
  logic [SAMPLE_BITS-1:0] rd_raw_q;
  logic                   rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_raw_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  // An entry never written since reset reads as zero.
  assign rd_data_o = rd_vld_q ? rd_raw_q : '0;

  `ATGAB_ASSERT_NEVER(a_no_rw_collision, rd_en_i && wr_en_i && (rd_addr_i == wr_addr_i), "ring read and write hit the same entry")

endmodule

FILE: design/atgab_alarm_core.sv
// Running sum, alarm flags and LED blink state updated once per word.
module atgab_alarm_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              fire_i,
  input  logic [atgab_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic [atgab_pkg::SAMPLE_BITS-1:0] old_i,
  input  logic                              gas_i,
  input  atgab_pkg::cfg_t                   cfg_i,
  output atgab_pkg::result_t                res_o
);
  import atgab_pkg::*;

  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             led_q, led_d;
  logic [CMP_W-1:0] sum_ext;
  logic             temp;
  logic             active;
  logic [CNT_W-1:0] period;
  logic [CNT_W:0]   cnt_inc;

  always_comb begin
    sum_d   = sum_q - SUM_W'(old_i) + SUM_W'(sample_i);
    sum_ext = CMP_W'(sum_d);
    temp    = sum_ext > CMP_W'(cfg_i.temp_sum_limit);
    active  = gas_i || temp;
    if (gas_i && temp) begin
      period = cfg_i.both_period_ticks;
    end else if (gas_i) begin
      period = cfg_i.gas_period_ticks;
    end else begin
      period = cfg_i.temp_period_ticks;
    end
    cnt_inc = (CNT_W + 1)'(cnt_q) + (CNT_W + 1)'(1);
    if (!active) begin
      cnt_d = '0;
      led_d = 1'b0;
    end else if (cnt_inc >= (CNT_W + 1)'(period)) begin
      cnt_d = '0;
      led_d = !led_q;
    end else begin
      cnt_d = cnt_inc[CNT_W-1:0];
      led_d = led_q;
    end
    res_o.led_on       = led_d;
    res_o.gas_alarm    = gas_i;
    res_o.temp_alarm   = temp;
    res_o.alarm_active = active;
    res_o.window_sum   = (sum_ext > CMP_W'(SUM_MAX)) ? SUM_MAX : sum_ext[OUT_SUM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
      led_q <= 1'b0;
    end else if (fire_i) begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      led_q <= led_d;
    end
  end

endmodule

FILE: design/atgab_out_queue.sv
// Small result queue that decouples the update stage from the output channel.
`include "averaged_temp_gas_alarm_blinker_top_assert.svh"

module atgab_out_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  atgab_pkg::result_t           push_data_i,
  output logic [atgab_pkg::QCNT_W-1:0] count_o,
  atgab_out_if.source                  out_o
);
  import atgab_pkg::*;

  result_t           slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              pop;
  result_t           head;

  assign pop = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assign head               = slot_q[rd_ptr_q];
  assign out_o.valid        = (count_q != '0);
  assign out_o.led_on       = head.led_on;
  assign out_o.gas_alarm    = head.gas_alarm;
  assign out_o.temp_alarm   = head.temp_alarm;
  assign out_o.alarm_active = head.alarm_active;
  assign out_o.window_sum   = head.window_sum;
  assign count_o            = count_q;

  `ATGAB_ASSERT(a_no_overflow, push_i |-> ((count_q < QCNT_W'(QUEUE_DEPTH)) || pop), "result queue overflow")

endmodule

FILE: design/averaged_temp_gas_alarm_blinker_top.sv
// Top level of the averaged temperature and gas alarm blinker.
// Each accepted word carries one converter sample and the gas bit; exactly one result word
// follows via the update stage and the result queue. A new word is accepted in every cycle
// while the result queue has room: the ring memory is read in the cycle of acceptance and
// written back in the next, and consecutive words use consecutive ring entries, so the only
// limit on the sustained rate of one word per cycle is the output side. The ring comes out of
// reset cleared through per-entry valid bits, so no clearing pass is needed. The register
// port is always ready; registers are to be written only while the block is idle.
`include "averaged_temp_gas_alarm_blinker_top_assert.svh"

module averaged_temp_gas_alarm_blinker_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  atgab_in_if.sink     in_i,
  atgab_out_if.source  out_o,
  atgab_cfg_if.sink    cfg_i
);
  import atgab_pkg::*;

  cfg_t                   cfg_q;
  logic [PTR_W-1:0]       ptr_q;
  logic                   s1_v_q;
  logic [SAMPLE_BITS-1:0] s1_sample_q;
  logic                   s1_gas_q;
  logic [PTR_W-1:0]       s1_slot_q;
  logic                   in_fire;
  logic [SAMPLE_BITS-1:0] old_sample;
  logic [QCNT_W-1:0]      q_count;
  logic [QCNT_W:0]        pending;
  result_t                res;

  assign pending    = (QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(s1_v_q);
  assign in_i.ready = (pending < (QCNT_W + 1)'(QUEUE_DEPTH));
  assign in_fire    = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_sum_limit    <= TEMP_SUM_LIMIT_RST;
      cfg_q.gas_period_ticks  <= GAS_PERIOD_TICKS_RST;
      cfg_q.temp_period_ticks <= TEMP_PERIOD_TICKS_RST;
      cfg_q.both_period_ticks <= BOTH_PERIOD_TICKS_RST;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_TEMP_SUM_LIMIT:    cfg_q.temp_sum_limit    <= cfg_i.data[OUT_SUM_W-1:0];
        REG_GAS_PERIOD_TICKS:  cfg_q.gas_period_ticks  <= cfg_i.data[CNT_W-1:0];
        REG_TEMP_PERIOD_TICKS: cfg_q.temp_period_ticks <= cfg_i.data[CNT_W-1:0];
        REG_BOTH_PERIOD_TICKS: cfg_q.both_period_ticks <= cfg_i.data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= in_fire;
      if (in_fire) begin
        ptr_q <= (ptr_q == PTR_W'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_sample_q <= SAMPLE_BITS'(in_i.adc_sample);
      s1_gas_q    <= in_i.gas_detected;
      s1_slot_q   <= ptr_q;
    end
  end

  atgab_ring_ram u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_addr_i (ptr_q),
    .rd_data_o (old_sample),
    .wr_en_i   (s1_v_q),
    .wr_addr_i (s1_slot_q),
    .wr_data_i (s1_sample_q)
  );

  atgab_alarm_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (s1_v_q),
    .sample_i (s1_sample_q),
    .old_i    (old_sample),
    .gas_i    (s1_gas_q),
    .cfg_i    (cfg_q),
    .res_o    (res)
  );

  atgab_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_v_q),
    .push_data_i (res),
    .count_o     (q_count),
    .out_o       (out_o)
  );

  `ATGAB_ASSERT(a_update_follows_accept, in_fire |=> s1_v_q, "accepted word did not reach the update stage")

endmodule
